### src/edt_pkg.sv
// ----------------------------------------------------------------------------
// edt_pkg
// Shared constants, codes and types of the edit distance threshold check.
// ----------------------------------------------------------------------------
package edt_pkg;

   // word geometry
   localparam int MAX_LEN   = 32;
   localparam int WORD_W    = 64;
   localparam int SYM_W     = 2;
   localparam int NUM_SYM   = 4;

   // field and counter widths
   localparam int CFG_W     = 6;
   localparam int DIST_W    = 6;
   localparam int LEN_W     = $clog2(MAX_LEN + 1);
   localparam int STEP_W    = $clog2(2 * MAX_LEN + 1);
   localparam int CNT_W     = $clog2(MAX_LEN + 1);

   // stream widths
   localparam int REQ_W     = 2 * WORD_W;
   localparam int RSP_W     = 8;

   // register file
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_WORD_LENGTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_DISTANCE = 2'd1;
   localparam logic [CFG_W-1:0]     MIN_DISTANCE_RST = 6'd3;

   // inputs of one dynamic programming lane
   typedef struct packed {
      logic              en;
      logic [SYM_W-1:0]  a_sym;
      logic [SYM_W-1:0]  b_sym;
      logic [DIST_W-1:0] left;
      logic [DIST_W-1:0] diag;
   } lane_in_type;

   // control from the sequencer to the merge stage
   typedef struct packed {
      logic load;
      logic early_far;
   } merge_ctrl_type;

   // column values of all lanes, entry 0 is the empty-word distance
   typedef logic [MAX_LEN:0][DIST_W-1:0] dist_vec_type;

endpackage

### src/edt_lane.sv
// ----------------------------------------------------------------------------
// edt_lane
// One column of the edit distance table, evaluated along anti-diagonals.
// ----------------------------------------------------------------------------
module edt_lane
   import edt_pkg::*;
(
   input  logic              clock,
   input  logic              load,
   input  logic [DIST_W-1:0] init_val,
   input  lane_in_type       lane_in,
   output logic [DIST_W-1:0] val,
   output logic [DIST_W-1:0] prev,
   output logic [SYM_W-1:0]  b_sym_out
);

   logic [DIST_W-1:0] val_ff, val_in;
   logic [DIST_W-1:0] prev_ff, prev_in;
   logic [SYM_W-1:0]  bsym_ff, bsym_in;
   logic [DIST_W-1:0] best;

   // cell update: match takes the diagonal, else smallest neighbor plus one
   always_comb begin
      best = lane_in.left;
      if (val_ff < best) begin
         best = val_ff;
      end
      if (lane_in.diag < best) begin
         best = lane_in.diag;
      end
      val_in  = val_ff;
      prev_in = prev_ff;
      if (load) begin
         val_in  = init_val;
         prev_in = init_val;
      end else if (lane_in.en) begin
         prev_in = val_ff;
         if (lane_in.a_sym == lane_in.b_sym) begin
            val_in = lane_in.diag;
         end else begin
            val_in = best + DIST_W'(1);
         end
      end
      bsym_in = lane_in.b_sym;
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      prev_ff <= prev_in;
      bsym_ff <= bsym_in;
   end

   assign val       = val_ff;
   assign prev      = prev_ff;
   assign b_sym_out = bsym_ff;

endmodule

### src/edt_prefilter.sv
// ----------------------------------------------------------------------------
// edt_prefilter
// Symbol counts of both words, one symbol pair a cycle while enabled, and the count bound.
// ----------------------------------------------------------------------------
module edt_prefilter
   import edt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic              en,
   input  logic [SYM_W-1:0]  sym_a,
   input  logic [SYM_W-1:0]  sym_b,
   output logic [DIST_W-1:0] bound
);

   localparam int SUM_W = CNT_W + 2;

   logic [NUM_SYM-1:0][CNT_W-1:0] ca_ff, ca_in;
   logic [NUM_SYM-1:0][CNT_W-1:0] cb_ff, cb_in;
   logic [SUM_W-1:0]              sum;

   // count update
   always_comb begin
      ca_in = ca_ff;
      cb_in = cb_ff;
      if (clear) begin
         ca_in = '0;
         cb_in = '0;
      end else if (en) begin
         ca_in[sym_a] = ca_ff[sym_a] + CNT_W'(1);
         cb_in[sym_b] = cb_ff[sym_b] + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ca_ff <= '0;
         cb_ff <= '0;
      end else begin
         ca_ff <= ca_in;
         cb_ff <= cb_in;
      end
   end

   // half the sum of absolute count differences
   always_comb begin
      sum = '0;
      for (int k = 0; k < NUM_SYM; k++) begin
         if (ca_ff[k] > cb_ff[k]) begin
            sum = sum + SUM_W'(ca_ff[k] - cb_ff[k]);
         end else begin
            sum = sum + SUM_W'(cb_ff[k] - ca_ff[k]);
         end
      end
   end

   assign bound = DIST_W'(sum >> 1);

endmodule

### src/edt_merge.sv
// ----------------------------------------------------------------------------
// edt_merge
// Picks the final column of the table, applies the threshold and holds the
// result transaction until it is taken.
// ----------------------------------------------------------------------------
module edt_merge
   import edt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  merge_ctrl_type    ctrl,
   input  dist_vec_type      vals,
   input  logic [LEN_W-1:0]  len,
   input  logic [CFG_W-1:0]  min_dist,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output logic              far_apart,
   output logic [DIST_W-1:0] distance,
   output logic              slot_free
);

   logic              valid_ff, valid_in;
   logic              far_ff, far_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic [DIST_W-1:0] dist_sel;

   // threshold against the selected column
   always_comb begin
      dist_sel = vals[len];
      far_in   = ctrl.early_far || (dist_sel >= min_dist);
      dist_in  = far_in ? '0 : dist_sel;
      valid_in = valid_ff;
      if (ctrl.load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         far_ff  <= far_in;
         dist_ff <= dist_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign far_apart  = far_ff;
   assign distance   = dist_ff;
   assign slot_free  = !valid_ff || rsp_tready;

endmodule

### src/edit_distance_threshold_check_top.sv
// ----------------------------------------------------------------------------
// edit_distance_threshold_check_top
// Edit distance of two equal-length words over four symbols, checked against
// a minimum distance, with a symbol-count prefilter for early exit.
// ----------------------------------------------------------------------------
//  channel | ports                         | contents
//  --------+-------------------------------+--------------------------------
//  req     | req_tvalid/tready/tdata       | word_a, word_b
//  rsp     | rsp_tvalid/tready/tdata       | far_apart, distance
//  csr     | csr_valid/ready/index/data    | word_length, min_distance
//
//  one word pair at a time; for length L the lanes sweep the 2L-1
//  anti-diagonals between the accept and the registered result
//  the count bound is ready after L steps and ends the item early when it
//  reaches min_distance, so an item can end before the full sweep
//  reset is synchronous; it empties the pipeline and restores the registers
//  a result that is not taken stalls the sequencer on its final step
// ----------------------------------------------------------------------------
module edit_distance_threshold_check_top
   import edt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [REQ_W-1:0]     req_tdata,   // word_a, word_b
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata,   // far_apart, distance, zero pad
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic                 state_ff, state_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [CFG_W-1:0]     min_ff, min_in;
   logic [WORD_W-1:0]    a_ff, a_in;
   logic [WORD_W-1:0]    a_sh_ff, a_sh_in;
   logic [WORD_W-1:0]    b_sh_ff, b_sh_in;

   logic                 start;
   logic                 run;
   logic                 done;
   logic                 full_done;
   logic                 early_cond;
   logic                 advance;
   logic                 slot_free;
   logic                 far_apart;
   logic [DIST_W-1:0]    distance;
   logic [DIST_W-1:0]    bound;
   merge_ctrl_type       mctrl;
   dist_vec_type         lane_val;
   logic [MAX_LEN:1][DIST_W-1:0] lane_prev;
   logic [MAX_LEN:1][SYM_W-1:0]  lane_bsym;

   // handshakes
   assign start      = req_tvalid && req_tready;
   assign run        = (state_ff == ST_RUN);
   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;

   // end of the sweep, or count bound already at the minimum
   assign full_done  = (step_ff >= STEP_W'({len_ff, 1'b0}));
   assign early_cond = (step_ff > STEP_W'(len_ff)) && (bound >= min_ff);
   assign done       = full_done || early_cond;
   assign advance    = run && !done;

   assign mctrl.load      = run && done && slot_free;
   assign mctrl.early_far = early_cond;

   // configuration registers, word length clamped to the lane count
   always_comb begin
      len_in = len_ff;
      min_in = min_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_WORD_LENGTH: begin
               if (csr_data > CFG_W'(MAX_LEN)) begin
                  len_in = LEN_W'(MAX_LEN);
               end else begin
                  len_in = LEN_W'(csr_data);
               end
            end
            REG_MIN_DISTANCE: begin
               min_in = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      if (start) begin
         state_in = ST_RUN;
         step_in  = STEP_W'(1);
      end else if (mctrl.load) begin
         state_in = ST_IDLE;
      end else if (advance) begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         len_ff   <= LEN_W'(MAX_LEN);
         min_ff   <= MIN_DISTANCE_RST;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         len_ff   <= len_in;
         min_ff   <= min_in;
      end
   end

   // word registers, shifted one symbol per step for the count and lane 1
   always_comb begin
      a_in    = a_ff;
      a_sh_in = a_sh_ff;
      b_sh_in = b_sh_ff;
      if (start) begin
         a_in    = req_tdata[WORD_W-1:0];
         a_sh_in = req_tdata[WORD_W-1:0];
         b_sh_in = req_tdata[REQ_W-1:WORD_W];
      end else if (advance) begin
         a_sh_in = a_sh_ff >> SYM_W;
         b_sh_in = b_sh_ff >> SYM_W;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      a_sh_ff <= a_sh_in;
      b_sh_ff <= b_sh_in;
   end

   // count prefilter
   edt_prefilter u_prefilter (
      .clock (clock),
      .reset (reset),
      .clear (start),
      .en    (advance && (step_ff <= STEP_W'(len_ff))),
      .sym_a (a_sh_ff[SYM_W-1:0]),
      .sym_b (b_sh_ff[SYM_W-1:0]),
      .bound (bound)
   );

   // column lanes of the table
   assign lane_val[0] = '0;

   for (genvar i = 1; i <= MAX_LEN; i++) begin : g_lane
      lane_in_type lin;

      always_comb begin
         lin.en    = advance && (LEN_W'(i) <= len_ff) && (step_ff >= STEP_W'(i)) &&
                     (step_ff < (STEP_W'(i) + STEP_W'(len_ff)));
         lin.a_sym = a_ff[SYM_W*(i-1) +: SYM_W];
         if (i == 1) begin
            lin.b_sym = b_sh_ff[SYM_W-1:0];
            lin.left  = step_ff[DIST_W-1:0];
            lin.diag  = step_ff[DIST_W-1:0] - DIST_W'(1);
         end else begin
            lin.b_sym = lane_bsym[(i > 1) ? i - 1 : 1];
            lin.left  = lane_val[i-1];
            lin.diag  = lane_prev[(i > 1) ? i - 1 : 1];
         end
      end

      edt_lane u_lane (
         .clock     (clock),
         .load      (start),
         .init_val  (DIST_W'(i)),
         .lane_in   (lin),
         .val       (lane_val[i]),
         .prev      (lane_prev[i]),
         .b_sym_out (lane_bsym[i])
      );
   end

   // merge and output register
   edt_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mctrl),
      .vals       (lane_val),
      .len        (len_ff),
      .min_dist   (min_ff),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .far_apart  (far_apart),
      .distance   (distance),
      .slot_free  (slot_free)
   );

   assign rsp_tdata = {{(RSP_W - 1 - DIST_W){1'b0}}, distance, far_apart};

`ifndef SYNTHESIS
   // accepted transaction starts the sweep at step one
   a_start: assert property (@(posedge clock) disable iff (reset)
      start |=> (state_ff == ST_RUN) && (step_ff == STEP_W'(1)))
      else $error("sweep did not start after accept");

   // step counter stays within the longest sweep
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      run |-> (step_ff <= STEP_W'(2 * MAX_LEN)))
      else $error("step counter ran past the sweep");

   // no result is written over one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      mctrl.load |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwritten before it was taken");

   // far results carry a zero distance
   a_far_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> (rsp_tdata[DIST_W:1] == '0))
      else $error("far result with nonzero distance");
`endif

endmodule
